/* rtl/variable_edge_histogram_defines.svh */
// Assertion macros for the variable edge histogram checker.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef VARIABLE_EDGE_HISTOGRAM_DEFINES_SVH
`define VARIABLE_EDGE_HISTOGRAM_DEFINES_SVH

// Check a property outside reset.
`define VEH_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define VEH_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* rtl/veh_pkg.sv */
// Shared types, codes and helpers for the variable edge histogram.
// No dependencies.
package veh_pkg;

    localparam int MAX_EDGES     = 7;
    localparam int COUNT_WIDTH   = 16;
    localparam int NUM_EDGE_REGS = 7;
    localparam int NUM_BINS      = MAX_EDGES - 1;
    localparam int BIN_AW        = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int PADDR_W       = 5;
    localparam int PDATA_W       = 32;

    // Operation codes
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_BELOW   = 2'd1;
    localparam logic [1:0] STAT_ABOVE   = 2'd2;
    localparam logic [1:0] STAT_BAD_BIN = 2'd3;

    // Register indexes
    localparam logic [2:0] REG_EDGES_IN_USE = 3'd0;
    localparam logic [2:0] REG_EDGE_0       = 3'd1;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] sample;
        logic [2:0]         read_bin;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  bin_index;
        logic [15:0] bin_count;
    } t_out;

    typedef logic [NUM_EDGE_REGS-1:0][31:0] t_edge_arr;

    typedef struct packed {
        logic [2:0] edges_in_use;
        t_edge_arr  edge_val;
    } t_cfg;

    typedef struct packed {
        logic [1:0] add_status;
        logic [2:0] add_bin;
        logic       read_ok;
    } t_lookup;

    // Clamp a counter value to the 16-bit reported count.
    function automatic logic [15:0] report_count(input logic [COUNT_WIDTH-1:0] c);
        logic [COUNT_WIDTH+15:0] w;
        w = {16'd0, c};
        if (w > (COUNT_WIDTH+16)'(16'hFFFF)) begin
            return 16'hFFFF;
        end
        return w[15:0];
    endfunction

endpackage

/* rtl/veh_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module veh_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 6
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port: hold data until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/veh_regs.sv */
// APB-style configuration registers: edge count and bin edges.
// Depends on veh_pkg.
module veh_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [veh_pkg::PADDR_W-1:0]   paddr,
    input  logic [veh_pkg::PDATA_W-1:0]   pwdata,
    output logic [veh_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output veh_pkg::t_cfg                 o_cfg
);

    logic [2:0]         r_edges_in_use;
    veh_pkg::t_edge_arr r_edge;
    logic               wr_stb;
    logic [2:0]         reg_idx;

    assign pready  = 1'b1;
    assign wr_stb  = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edges_in_use <= 3'd2;
            for (int k = 0; k < veh_pkg::NUM_EDGE_REGS; k++) begin
                r_edge[k] <= 32'(k * 65536);
            end
        end else if (wr_stb) begin
            if (reg_idx == veh_pkg::REG_EDGES_IN_USE) begin
                r_edges_in_use <= pwdata[2:0];
            end
            for (int k = 0; k < veh_pkg::NUM_EDGE_REGS; k++) begin
                if (reg_idx == veh_pkg::REG_EDGE_0 + 3'(k)) begin
                    r_edge[k] <= pwdata;
                end
            end
        end
    end

    // Read mux, one compare per register
    always_comb begin
        prdata = '0;
        if (reg_idx == veh_pkg::REG_EDGES_IN_USE) begin
            prdata = {29'd0, r_edges_in_use};
        end
        for (int k = 0; k < veh_pkg::NUM_EDGE_REGS; k++) begin
            if (reg_idx == veh_pkg::REG_EDGE_0 + 3'(k)) begin
                prdata = r_edge[k];
            end
        end
    end

    assign o_cfg.edges_in_use = r_edges_in_use;
    assign o_cfg.edge_val     = r_edge;

endmodule

/* rtl/veh_bin_find.sv */
// Bin lookup: priority scan of the edges for a sample, and read index check.
// Depends on veh_pkg.
module veh_bin_find (
    input  veh_pkg::t_cfg      i_cfg,
    input  logic signed [31:0] i_sample,
    input  logic [2:0]         i_read_bin,
    output veh_pkg::t_lookup   o_lookup
);

    logic [2:0] n_act;
    logic       found;
    logic       top_eq;
    logic [2:0] bin;

    // Clamp the edge count to the supported range
    always_comb begin
        if (i_cfg.edges_in_use < 3'd2) begin
            n_act = 3'd2;
        end else if (i_cfg.edges_in_use > 3'(veh_pkg::MAX_EDGES)) begin
            n_act = 3'(veh_pkg::MAX_EDGES);
        end else begin
            n_act = i_cfg.edges_in_use;
        end
    end

    // First edge above the sample picks the bin; equal to top edge lands in last bin
    always_comb begin
        found  = 1'b0;
        bin    = 3'd0;
        top_eq = 1'b0;
        for (int k = 1; k < veh_pkg::MAX_EDGES; k++) begin
            if (!found && (3'(k) < n_act) &&
                (i_sample < $signed(i_cfg.edge_val[k]))) begin
                found = 1'b1;
                bin   = 3'(k - 1);
            end
            if ((3'(k) == n_act - 3'd1) && (i_sample == $signed(i_cfg.edge_val[k]))) begin
                top_eq = 1'b1;
            end
        end
        if (i_sample < $signed(i_cfg.edge_val[0])) begin
            o_lookup.add_status = veh_pkg::STAT_BELOW;
            o_lookup.add_bin    = 3'd0;
        end else if (found) begin
            o_lookup.add_status = veh_pkg::STAT_OK;
            o_lookup.add_bin    = bin;
        end else if (top_eq) begin
            o_lookup.add_status = veh_pkg::STAT_OK;
            o_lookup.add_bin    = n_act - 3'd2;
        end else begin
            o_lookup.add_status = veh_pkg::STAT_ABOVE;
            o_lookup.add_bin    = 3'd0;
        end
        o_lookup.read_ok = (i_read_bin < n_act - 3'd1);
    end

endmodule

/* rtl/variable_edge_histogram.sv */
// Variable edge histogram: counts signed Q16.16 samples into up to six bins.
// An accepted item waits in the update state for the read-modify-write of the count RAM;
// the output register takes its result once not stalled; only then is a new item taken.
// Reset: synchronous, clears control state and all bin valid bits, so every count
// reads as zero at once; no clearing pass is needed.
module variable_edge_histogram (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  veh_pkg::t_in                i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output veh_pkg::t_out               o_out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [veh_pkg::PADDR_W-1:0] paddr,
    input  logic [veh_pkg::PDATA_W-1:0] pwdata,
    output logic [veh_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_UPD  = 1'b1;

    veh_pkg::t_cfg    cfg;
    veh_pkg::t_lookup lookup;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic [veh_pkg::NUM_BINS-1:0] r_valid, n_valid;
    veh_pkg::t_out r_out;

    logic [1:0] r_op;
    logic [1:0] r_status;
    logic [2:0] r_bin;

    logic accept, load;
    logic add_ok, read_ok;
    logic rd_en, wr_en;
    logic [veh_pkg::BIN_AW-1:0] rd_addr;
    logic [veh_pkg::COUNT_WIDTH-1:0] rd_data, base, incr;
    veh_pkg::t_out result;

    veh_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    veh_bin_find u_find (
        .i_cfg      (cfg),
        .i_sample   (i_in_data.sample),
        .i_read_bin (i_in_data.read_bin),
        .o_lookup   (lookup)
    );

    veh_ram #(
        .WIDTH (veh_pkg::COUNT_WIDTH),
        .DEPTH (veh_pkg::NUM_BINS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_bin[veh_pkg::BIN_AW-1:0]),
        .i_wr_data (incr),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Input side: one item in flight
    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign add_ok     = (i_in_data.operation == veh_pkg::OP_ADD) &&
                        (lookup.add_status == veh_pkg::STAT_OK);
    assign read_ok    = (i_in_data.operation == veh_pkg::OP_READ) && lookup.read_ok;
    assign rd_en      = accept && (add_ok || read_ok);
    assign rd_addr    = read_ok ? i_in_data.read_bin[veh_pkg::BIN_AW-1:0]
                                : lookup.add_bin[veh_pkg::BIN_AW-1:0];

    // Capture the decoded item
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op <= i_in_data.operation;
            if (i_in_data.operation == veh_pkg::OP_ADD) begin
                r_status <= lookup.add_status;
                r_bin    <= lookup.add_bin;
            end else if (i_in_data.operation == veh_pkg::OP_READ && !lookup.read_ok) begin
                r_status <= veh_pkg::STAT_BAD_BIN;
                r_bin    <= 3'd0;
            end else if (read_ok) begin
                r_status <= veh_pkg::STAT_OK;
                r_bin    <= i_in_data.read_bin;
            end else begin
                r_status <= veh_pkg::STAT_OK;
                r_bin    <= 3'd0;
            end
        end
    end

    // Modify: a count never written since clear reads as zero
    assign base = r_valid[r_bin[veh_pkg::BIN_AW-1:0]] ? rd_data : '0;
    assign incr = (&base) ? base : base + veh_pkg::COUNT_WIDTH'(1);
    assign load = (r_state == S_UPD) && (!r_out_valid || !i_out_stall);
    assign wr_en = load && (r_op == veh_pkg::OP_ADD) && (r_status == veh_pkg::STAT_OK);

    // Build the result
    always_comb begin
        result.status    = r_status;
        result.bin_index = r_bin;
        result.bin_count = 16'd0;
        if (r_status == veh_pkg::STAT_OK) begin
            if (r_op == veh_pkg::OP_ADD) begin
                result.bin_count = veh_pkg::report_count(incr);
            end else if (r_op == veh_pkg::OP_READ) begin
                result.bin_count = veh_pkg::report_count(base);
            end
        end
    end

    // Next-state logic
    always_comb begin
        n_state     = r_state;
        n_valid     = r_valid;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (load) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    if (r_op == veh_pkg::OP_CLEAR) begin
                        n_valid = '0;
                    end else if (wr_en) begin
                        n_valid[r_bin[veh_pkg::BIN_AW-1:0]] = 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Output register: hold while stalled
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* rtl/veh_checker.sv */
// Port-level checks for the variable edge histogram, bound to the top level.
// Depends on veh_pkg and variable_edge_histogram_defines.svh.
`include "variable_edge_histogram_defines.svh"

module veh_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input veh_pkg::t_in  i_in_data,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input veh_pkg::t_out o_out_data,
    input logic          pready
);

    // A stalled result holds its value
    `VEH_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data), "stalled result changed")

    // An input transfer blocks the next cycle while the count is updated
    `VEH_ASSERT(a_one_in_flight, i_in_valid && !o_in_stall |=> o_in_stall, "second item taken during update")

    // Error results carry no bin and no count
    `VEH_ASSERT(a_err_zero, o_out_valid && (o_out_data.status != veh_pkg::STAT_OK) |-> (o_out_data.bin_index == 3'd0) && (o_out_data.bin_count == 16'd0), "error result carries data")

    // Reset empties the output and the config port is always ready
    `VEH_ASSERT_ALWAYS(a_rst_out, !i_rst_n |=> !o_out_valid && pready, "output valid after reset")

endmodule

bind variable_edge_histogram veh_checker u_veh_checker (.*);

/* test/tb_variable_edge_histogram.sv */
// Self-checking testbench for variable_edge_histogram: directed table, random phases over
// several edge settings, and a stretch with no idling. Depends on veh_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_variable_edge_histogram;

    localparam logic [1:0] OP_RESERVED    = 2'd3;
    localparam int         WATCHDOG_LIMIT = 4000;
    localparam int         RANDOM_PHASES  = 7;
    localparam int         PHASE_ITEMS    = 250;
    localparam int         CALM_ITEMS     = 180;

    typedef struct packed {
        veh_pkg::t_in  item;
        logic          typed;
        veh_pkg::t_out want;
    } t_row;

    // Directed rows run with the reset edges: n = 2, edge_0 = 0.0, edge_1 = 1.0
    localparam int N_DIRECTED = 18;
    localparam t_row DIRECTED [N_DIRECTED] = '{
        '{'{veh_pkg::OP_READ,  32'sd0,         3'd0}, 1'b1,
          '{veh_pkg::STAT_OK,      3'd0, 16'd0}},
        '{'{veh_pkg::OP_READ,  32'sd0,         3'd1}, 1'b1,
          '{veh_pkg::STAT_BAD_BIN, 3'd0, 16'd0}},
        '{'{veh_pkg::OP_READ,  -32'sd1,        3'd7}, 1'b1,
          '{veh_pkg::STAT_BAD_BIN, 3'd0, 16'd0}},
        '{'{veh_pkg::OP_ADD,   32'sd0,         3'd0}, 1'b1,
          '{veh_pkg::STAT_OK,      3'd0, 16'd1}},
        '{'{veh_pkg::OP_ADD,   32'sd65536,     3'd0}, 1'b1,
          '{veh_pkg::STAT_OK,      3'd0, 16'd2}},
        '{'{veh_pkg::OP_ADD,   32'sd65535,     3'd5}, 1'b0, '0},
        '{'{veh_pkg::OP_ADD,   -32'sd1,        3'd0}, 1'b1,
          '{veh_pkg::STAT_BELOW,   3'd0, 16'd0}},
        '{'{veh_pkg::OP_ADD,   32'sh8000_0000, 3'd0}, 1'b1,
          '{veh_pkg::STAT_BELOW,   3'd0, 16'd0}},
        '{'{veh_pkg::OP_ADD,   32'sd65537,     3'd0}, 1'b1,
          '{veh_pkg::STAT_ABOVE,   3'd0, 16'd0}},
        '{'{veh_pkg::OP_ADD,   32'sh7FFF_FFFF, 3'd7}, 1'b1,
          '{veh_pkg::STAT_ABOVE,   3'd0, 16'd0}},
        '{'{OP_RESERVED,       -32'sd1,        3'd7}, 1'b1,
          '{veh_pkg::STAT_OK,      3'd0, 16'd0}},
        '{'{veh_pkg::OP_READ,  32'sd0,         3'd0}, 1'b0, '0},
        '{'{veh_pkg::OP_CLEAR, 32'sd0,         3'd0}, 1'b1,
          '{veh_pkg::STAT_OK,      3'd0, 16'd0}},
        '{'{veh_pkg::OP_READ,  32'sd0,         3'd0}, 1'b1,
          '{veh_pkg::STAT_OK,      3'd0, 16'd0}},
        '{'{veh_pkg::OP_ADD,   32'sd32768,     3'd0}, 1'b0, '0},
        '{'{veh_pkg::OP_ADD,   32'sd1,         3'd7}, 1'b0, '0},
        '{'{veh_pkg::OP_CLEAR, -32'sd1,        3'd7}, 1'b1,
          '{veh_pkg::STAT_OK,      3'd0, 16'd0}},
        '{'{veh_pkg::OP_READ,  32'sh7FFF_FFFF, 3'd0}, 1'b1,
          '{veh_pkg::STAT_OK,      3'd0, 16'd0}}
    };

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    veh_pkg::t_in                 in_data = '0;
    logic                         out_stall = 1'b0;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [veh_pkg::PADDR_W-1:0]  paddr = '0;
    logic [veh_pkg::PDATA_W-1:0]  pwdata = '0;
    logic                         o_in_stall;
    logic                         o_out_valid;
    veh_pkg::t_out                o_out_data;
    logic [veh_pkg::PDATA_W-1:0]  prdata;
    logic                         pready;

    // Predictor state: its own copy of the edges, the edge count and the bin counters
    logic [2:0]                      model_edges_in_use = 3'd2;
    logic signed [31:0]              model_edges [veh_pkg::NUM_EDGE_REGS];
    logic [veh_pkg::COUNT_WIDTH-1:0] model_counts [veh_pkg::NUM_BINS];

    veh_pkg::t_out expected_results [$];
    bit   calm = 1'b0;
    int   error_count = 0;
    int   items_sent = 0;
    int   results_checked = 0;
    int   quiet_cycles = 0;

    variable_edge_histogram i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #6 clk = ~clk;

    // Predict one item's result against the model edges and update the model counters
    function automatic veh_pkg::t_out predict_bin(input veh_pkg::t_in item);
        veh_pkg::t_out r;
        int   n;
        bit   found;
        r = '0;
        found = 1'b0;
        n = (model_edges_in_use < 3'd2) ? 2 : int'(model_edges_in_use);
        case (item.operation)
            veh_pkg::OP_ADD: begin
                if ($signed(item.sample) < model_edges[0]) begin
                    r.status = veh_pkg::STAT_BELOW;
                end else begin
                    for (int k = 1; k < n; k++) begin
                        if (!found && $signed(item.sample) < model_edges[k]) begin
                            r.bin_index = 3'(k - 1);
                            found = 1'b1;
                        end
                    end
                    // The top edge itself still belongs to the last bin
                    if (!found && $signed(item.sample) == model_edges[n-1]) begin
                        r.bin_index = 3'(n - 2);
                        found = 1'b1;
                    end
                    if (found) begin
                        if (model_counts[r.bin_index] != '1) begin
                            model_counts[r.bin_index]++;
                        end
                        r.bin_count = 16'(model_counts[r.bin_index]);
                    end else begin
                        r.status = veh_pkg::STAT_ABOVE;
                    end
                end
            end
            veh_pkg::OP_CLEAR: begin
                foreach (model_counts[k]) model_counts[k] = '0;
            end
            veh_pkg::OP_READ: begin
                if (int'(item.read_bin) < n - 1) begin
                    r.bin_index = item.read_bin;
                    r.bin_count = 16'(model_counts[item.read_bin]);
                end else begin
                    r.status = veh_pkg::STAT_BAD_BIN;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Favor samples on and right around the edges, where the bin decision flips
    function automatic logic [31:0] edge_biased_sample();
        int unsigned roll;
        int unsigned k;
        roll = $urandom_range(99);
        k = $urandom_range(veh_pkg::NUM_EDGE_REGS - 1);
        if (roll < 45) begin
            return model_edges[k] + 32'($urandom_range(4)) - 32'd2;
        end
        if (roll < 75) begin
            return model_edges[k] + 32'($urandom_range(32'h3FFFF)) - 32'h1FFFF;
        end
        if (roll < 85) begin
            case ($urandom_range(3))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return $urandom;
    endfunction

    function automatic veh_pkg::t_in random_item();
        veh_pkg::t_in item;
        int unsigned  roll;
        roll = $urandom_range(99);
        if (roll < 68) begin
            item.operation = veh_pkg::OP_ADD;
        end else if (roll < 72) begin
            item.operation = veh_pkg::OP_CLEAR;
        end else if (roll < 94) begin
            item.operation = veh_pkg::OP_READ;
        end else begin
            item.operation = OP_RESERVED;
        end
        item.sample   = edge_biased_sample();
        item.read_bin = 3'($urandom_range(7));
        return item;
    endfunction

    function automatic bit idle_now();
        return !calm && ($urandom_range(99) < 31);
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("MISMATCH result %0d %s: got %0d, want %0d",
                 results_checked, what, got, want);
        error_count++;
    endtask

    // Hold valid across transfers; lower it only for idle cycles or when stimulus pauses
    task automatic send_item(input veh_pkg::t_in item, input bit typed,
                             input veh_pkg::t_out want);
        veh_pkg::t_out predicted;
        while (idle_now()) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (o_in_stall !== 1'b0) @(posedge clk);
        predicted = predict_bin(item);
        expected_results.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    task automatic write_reg(input int unsigned idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= veh_pkg::PADDR_W'(idx * 4);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1) @(posedge clk);
        if (idx == veh_pkg::REG_EDGES_IN_USE) begin
            model_edges_in_use = value[2:0];
        end else begin
            model_edges[idx - veh_pkg::REG_EDGE_0] = value;
        end
    endtask

    // Drain the block, then rewrite every register
    task automatic load_config(input logic [2:0] n, input veh_pkg::t_edge_arr edges);
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        write_reg(veh_pkg::REG_EDGES_IN_USE, {29'd0, n});
        for (int k = 0; k < veh_pkg::NUM_EDGE_REGS; k++) begin
            write_reg(veh_pkg::REG_EDGE_0 + k, edges[k]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Receiver side: random stall except during the calm stretch
    always @(posedge clk) begin
        out_stall <= !calm && ($urandom_range(99) < 31);
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge clk) begin
        if (rst_n && o_out_valid === 1'b1 && !out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("with nothing expected, status", o_out_data.status, 0);
            end else begin
                veh_pkg::t_out want;
                want = expected_results.pop_front();
                if (o_out_data.status !== want.status)
                    report_mismatch("status", o_out_data.status, want.status);
                if (o_out_data.bin_index !== want.bin_index)
                    report_mismatch("bin_index", o_out_data.bin_index, want.bin_index);
                if (o_out_data.bin_count !== want.bin_count)
                    report_mismatch("bin_count", o_out_data.bin_count, want.bin_count);
            end
            results_checked++;
        end
    end

    // End the run when nothing moves for too long
    always @(posedge clk) begin
        if (!rst_n || psel || (in_valid && o_in_stall === 1'b0)
                || (o_out_valid === 1'b1 && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        veh_pkg::t_edge_arr edges;
        logic [2:0]         n;
        int                 sorted [$];

        for (int k = 0; k < veh_pkg::NUM_EDGE_REGS; k++) model_edges[k] = 32'(k * 65536);
        foreach (model_counts[k]) model_counts[k] = '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table against the reset edges
        foreach (DIRECTED[i]) send_item(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].want);

        // Random phases, each under its own edge setting
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            for (int k = 0; k < veh_pkg::NUM_EDGE_REGS; k++) edges[k] = $urandom;
            case (p)
                0: begin
                    n = 3'd7;
                    edges = {32'sd6553600, 32'sd262144, 32'sd65536, 32'sd32768,
                             32'sd0, -32'sd65536, -32'sd196608};
                end
                1: begin
                    // count below two acts as two; full signed range in one bin
                    n = 3'd0;
                    edges[0] = 32'h8000_0000;
                    edges[1] = 32'h7FFF_FFFF;
                end
                2: begin
                    n = 3'd1;
                    edges[0] = -32'sd5;
                    edges[1] = 32'sd5;
                end
                3: begin
                    // edges not ascending: priority scan decides
                    n = 3'($urandom_range(2, 7));
                end
                4: begin
                    // repeated edges leave empty bins
                    n = 3'd5;
                    edges[0] = 32'sd0;
                    edges[1] = 32'sd0;
                    edges[2] = 32'sd65536;
                    edges[3] = 32'sd65536;
                    edges[4] = 32'sd131072;
                end
                5: begin
                    sorted.delete();
                    for (int k = 0; k < veh_pkg::NUM_EDGE_REGS; k++) begin
                        sorted.push_back(int'($urandom));
                    end
                    sorted.sort();
                    for (int k = 0; k < veh_pkg::NUM_EDGE_REGS; k++) edges[k] = sorted[k];
                    n = 3'($urandom_range(2, 7));
                end
                default: begin
                    n = 3'd7;
                    edges = {32'h7FFF_FFFF, 32'sd65536, 32'sd1, 32'sd0,
                             -32'sd1, -32'sd65536, 32'h8000_0000};
                end
            endcase
            load_config(n, edges);
            repeat (PHASE_ITEMS) send_item(random_item(), 1'b0, '0);
        end

        // Continuous input with no idling and no output stalls under the reset edges
        for (int k = 0; k < veh_pkg::NUM_EDGE_REGS; k++) edges[k] = 32'(k * 65536);
        load_config(3'd2, edges);
        calm = 1'b1;
        repeat (CALM_ITEMS) send_item(random_item(), 1'b0, '0);
        calm = 1'b0;
        in_valid <= 1'b0;

        // Drain and let any stray result show up
        while (expected_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Covered %0d input transfers and %0d result transfers over %0d edge settings,",
                 items_sent, results_checked, RANDOM_PHASES + 1);
        $display("including reserved operations, bad read indexes and a run with no idling.");
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
